// ----- rtl/smm_pkg.sv -----
package smm_pkg;

  localparam int MAX_DIM_DEF   = 8;
  localparam int FRAC_BITS_DEF = 16;

  localparam int DIM_W    = 4;
  localparam int IDX_W    = 3;
  localparam int ADDR_W   = 6;
  localparam int DATA_W   = 32;
  localparam int DEPTH    = 64;
  localparam int CFG_AW   = 4;
  localparam int CFG_DW   = 32;

  localparam logic [1:0] REQ_LOAD_A  = 2'd0;
  localparam logic [1:0] REQ_LOAD_B  = 2'd1;
  localparam logic [1:0] REQ_COMPUTE = 2'd2;

  localparam logic [1:0] REG_INNER_LEN = 2'd0;
  localparam logic [1:0] REG_OUT_COLS  = 2'd1;
  localparam logic [1:0] REG_OUT_ROWS  = 2'd2;

  typedef struct packed {
    logic [1:0]               req_type;
    logic [ADDR_W-1:0]        elem_index;
    logic signed [DATA_W-1:0] elem_value;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]        result_index;
    logic signed [DATA_W-1:0] result_value;
    logic                     last;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic             wr_a;
    logic             wr_b;
    logic             issue;
    logic             clear;
    logic             emit;
    logic             last;
    logic [IDX_W-1:0] k;
    logic [IDX_W-1:0] r;
    logic [IDX_W-1:0] c;
  } dp_cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } dp_status_t;

endpackage

// ----- rtl/smm_ram.sv -----
module smm_ram #(
  parameter int WIDTH = smm_pkg::DATA_W,
  parameter int DEPTH = smm_pkg::DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/smm_ctrl.sv -----
module smm_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [1:0]                   req_type,
  input  logic [smm_pkg::DIM_W-1:0]    dim_inner,
  input  logic [smm_pkg::DIM_W-1:0]    dim_cols,
  input  logic [smm_pkg::DIM_W-1:0]    dim_rows,
  input  smm_pkg::dp_status_t          status,
  output logic                         busy,
  output smm_pkg::dp_cmd_t             cmd
);

  smm_pkg::state_t state_r, state_nxt;
  logic [smm_pkg::IDX_W-1:0] k_r, k_nxt;
  logic [smm_pkg::IDX_W-1:0] r_r, r_nxt;
  logic [smm_pkg::IDX_W-1:0] c_r, c_nxt;
  logic accept;
  logic k_last, c_last, r_last;

  assign accept = start && (state_r == smm_pkg::ST_IDLE);
  assign k_last = ({1'b0, k_r} + 4'd1) == dim_inner;
  assign c_last = ({1'b0, c_r} + 4'd1) == dim_cols;
  assign r_last = ({1'b0, r_r} + 4'd1) == dim_rows;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= smm_pkg::ST_IDLE;
      k_r     <= '0;
      r_r     <= '0;
      c_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      r_r     <= r_nxt;
      c_r     <= c_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    r_nxt     = r_r;
    c_nxt     = c_r;
    cmd       = '0;
    cmd.k     = k_r;
    cmd.r     = r_r;
    cmd.c     = c_r;
    cmd.last  = r_last && c_last;
    busy      = 1'b1;
    case (state_r)
      smm_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (accept) begin
          cmd.wr_a = (req_type == smm_pkg::REQ_LOAD_A);
          cmd.wr_b = (req_type == smm_pkg::REQ_LOAD_B);
          // An empty result shape gives no transfer at all.
          if (req_type == smm_pkg::REQ_COMPUTE && dim_cols != '0 && dim_rows != '0) begin
            cmd.clear = 1'b1;
            k_nxt     = '0;
            r_nxt     = '0;
            c_nxt     = '0;
            state_nxt = smm_pkg::ST_ISSUE;
          end
        end
      end
      smm_pkg::ST_ISSUE: begin
        if (dim_inner == '0) begin
          state_nxt = smm_pkg::ST_DRAIN;
        end else begin
          cmd.issue = 1'b1;
          if (k_last) begin
            k_nxt     = '0;
            state_nxt = smm_pkg::ST_DRAIN;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
      end
      smm_pkg::ST_DRAIN: begin
        // The accumulator is final once no product is left in flight.
        if (!status.pipe_busy) begin
          cmd.emit  = 1'b1;
          cmd.clear = 1'b1;
          if (c_last) begin
            c_nxt = '0;
            r_nxt = r_r + 1'b1;
          end else begin
            c_nxt = c_r + 1'b1;
          end
          state_nxt = (r_last && c_last) ? smm_pkg::ST_IDLE : smm_pkg::ST_ISSUE;
        end
      end
      default: begin
        state_nxt = smm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/smm_dpath.sv -----
module smm_dpath #(
  parameter int MAX_DIM   = smm_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS = smm_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  smm_pkg::in_item_t            in_item,
  input  logic [smm_pkg::DIM_W-1:0]    dim_cols,
  input  logic [smm_pkg::DIM_W-1:0]    dim_inner,
  input  smm_pkg::dp_cmd_t             cmd,
  output smm_pkg::dp_status_t          status,
  output logic                         out_valid,
  output smm_pkg::out_item_t           out_item
);

  localparam int PROD_W = 2 * smm_pkg::DATA_W;
  localparam int ACC_W  = PROD_W + $clog2(MAX_DIM) + 1;

  logic [smm_pkg::ADDR_W-1:0] a_raddr, b_raddr;
  logic [smm_pkg::ADDR_W:0]   a_addr_w, b_addr_w, res_idx_w;
  logic [smm_pkg::DATA_W-1:0] a_rdata, b_rdata;
  logic signed [smm_pkg::DATA_W-1:0] a_s, b_s;

  logic                     rd_vld_r, mul_vld_r;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [ACC_W-1:0]  shifted;
  logic [ACC_W-32:0]        upper;
  logic signed [smm_pkg::DATA_W-1:0] sat_val;

  smm_pkg::out_item_t out_r, out_nxt;
  logic               out_valid_r;

  // A is inner-by-columns, B is rows-by-inner.
  assign a_addr_w  = 7'(cmd.k) * 7'(dim_cols) + 7'(cmd.c);
  assign b_addr_w  = 7'(cmd.r) * 7'(dim_inner) + 7'(cmd.k);
  assign res_idx_w = 7'(cmd.r) * 7'(dim_cols) + 7'(cmd.c);
  assign a_raddr   = a_addr_w[smm_pkg::ADDR_W-1:0];
  assign b_raddr   = b_addr_w[smm_pkg::ADDR_W-1:0];

  smm_ram #(.WIDTH(smm_pkg::DATA_W), .DEPTH(smm_pkg::DEPTH)) u_a_ram (
    .clk   (clk),
    .we    (cmd.wr_a),
    .waddr (in_item.elem_index),
    .wdata (in_item.elem_value),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  smm_ram #(.WIDTH(smm_pkg::DATA_W), .DEPTH(smm_pkg::DEPTH)) u_b_ram (
    .clk   (clk),
    .we    (cmd.wr_b),
    .waddr (in_item.elem_index),
    .wdata (in_item.elem_value),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  assign a_s      = $signed(a_rdata);
  assign b_s      = $signed(b_rdata);
  assign prod_nxt = a_s * b_s;

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.clear) begin
      acc_nxt = '0;
    end else if (mul_vld_r) begin
      acc_nxt = acc_r + ACC_W'(prod_r);
    end
  end

  // In range only when every bit from 31 up equals the sign.
  assign shifted = acc_r >>> FRAC_BITS;
  assign upper   = shifted[ACC_W-1:31];

  always_comb begin
    if ((&upper) || !(|upper)) begin
      sat_val = shifted[smm_pkg::DATA_W-1:0];
    end else if (shifted[ACC_W-1]) begin
      sat_val = {1'b1, {(smm_pkg::DATA_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(smm_pkg::DATA_W-1){1'b1}}};
    end
  end

  always_comb begin
    out_nxt = out_r;
    if (cmd.emit) begin
      out_nxt.result_index = res_idx_w[smm_pkg::ADDR_W-1:0];
      out_nxt.result_value = sat_val;
      out_nxt.last         = cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r    <= 1'b0;
      mul_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r    <= cmd.issue;
      mul_vld_r   <= rd_vld_r;
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    out_r  <= out_nxt;
  end

  assign status.pipe_busy = rd_vld_r || mul_vld_r;
  assign out_valid        = out_valid_r;
  assign out_item         = out_r;

endmodule

// ----- rtl/small_matrix_multiply_unit.sv -----
// Fixed-point matrix product unit. Load commands (start with busy low) write one
// element of A or B in a single cycle and leave busy low. A compute command raises
// busy and produces out_cols*out_rows results in row-major order; each result comes
// from the single shared multiply-accumulate that reads one A and one B element per
// cycle from the two element memories, then a multiplier stage and an accumulate
// stage. Each result is shown for exactly one cycle with out_valid high; the receiver
// cannot stall, so it must take every transfer as it comes. Busy falls together with
// the final result, which carries last. Dimensions above MAX_DIM are treated as
// MAX_DIM.
module small_matrix_multiply_unit #(
  parameter int MAX_DIM   = smm_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS = smm_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  smm_pkg::in_item_t            in_item,
  output logic                         out_valid,
  output smm_pkg::out_item_t           out_item,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [smm_pkg::CFG_AW-1:0]   paddr,
  input  logic [smm_pkg::CFG_DW-1:0]   pwdata,
  output logic [smm_pkg::CFG_DW-1:0]   prdata,
  output logic                         pready
);

  logic [smm_pkg::DIM_W-1:0] inner_len_r, inner_len_nxt;
  logic [smm_pkg::DIM_W-1:0] out_cols_r, out_cols_nxt;
  logic [smm_pkg::DIM_W-1:0] out_rows_r, out_rows_nxt;
  logic [smm_pkg::DIM_W-1:0] dim_inner, dim_cols, dim_rows;
  logic [1:0]                reg_sel;
  logic                      cfg_wr;

  smm_pkg::dp_cmd_t    cmd;
  smm_pkg::dp_status_t status;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    inner_len_nxt = inner_len_r;
    out_cols_nxt  = out_cols_r;
    out_rows_nxt  = out_rows_r;
    if (cfg_wr) begin
      case (reg_sel)
        smm_pkg::REG_INNER_LEN: inner_len_nxt = pwdata[smm_pkg::DIM_W-1:0];
        smm_pkg::REG_OUT_COLS:  out_cols_nxt  = pwdata[smm_pkg::DIM_W-1:0];
        smm_pkg::REG_OUT_ROWS:  out_rows_nxt  = pwdata[smm_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_len_r <= 4'd1;
      out_cols_r  <= 4'd1;
      out_rows_r  <= 4'd1;
    end else begin
      inner_len_r <= inner_len_nxt;
      out_cols_r  <= out_cols_nxt;
      out_rows_r  <= out_rows_nxt;
    end
  end

  always_comb begin
    case (reg_sel)
      smm_pkg::REG_INNER_LEN: prdata = 32'(inner_len_r);
      smm_pkg::REG_OUT_COLS:  prdata = 32'(out_cols_r);
      smm_pkg::REG_OUT_ROWS:  prdata = 32'(out_rows_r);
      default:                prdata = '0;
    endcase
  end

  assign dim_inner = (inner_len_r > 4'(MAX_DIM)) ? 4'(MAX_DIM) : inner_len_r;
  assign dim_cols  = (out_cols_r  > 4'(MAX_DIM)) ? 4'(MAX_DIM) : out_cols_r;
  assign dim_rows  = (out_rows_r  > 4'(MAX_DIM)) ? 4'(MAX_DIM) : out_rows_r;

  smm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .req_type  (in_item.req_type),
    .dim_inner (dim_inner),
    .dim_cols  (dim_cols),
    .dim_rows  (dim_rows),
    .status    (status),
    .busy      (busy),
    .cmd       (cmd)
  );

  smm_dpath #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .dim_cols  (dim_cols),
    .dim_inner (dim_inner),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ----- rtl/smm_checker.sv -----
module smm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input smm_pkg::in_item_t   in_item,
  input logic                out_valid,
  input smm_pkg::out_item_t  out_item
);

  // Results never come in consecutive cycles.
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two result transfers in consecutive cycles");

  a_mid_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.last) |-> busy)
    else $error("non-final result shown while not busy");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.last) |-> !busy)
    else $error("busy still high with the final result");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.req_type != smm_pkg::REQ_COMPUTE) |=> (!busy && !out_valid))
    else $error("load or unused command started a run");

endmodule

bind small_matrix_multiply_unit smm_checker u_smm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);

// ----- dv/tb_small_matrix_multiply_unit.sv -----
`timescale 1ns / 1ps

module tb_small_matrix_multiply_unit;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int FRAC = smm_pkg::FRAC_BITS_DEF;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT = 2000000;
  localparam logic signed [79:0] SAT_POS = 80'sd2147483647;
  localparam logic signed [79:0] SAT_NEG = -80'sd2147483648;
  localparam logic signed [31:0] VAL_MAX = 32'h7FFF_FFFF;
  localparam logic signed [31:0] VAL_MIN = 32'h8000_0000;

  logic                        clk;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  smm_pkg::in_item_t           in_item;
  logic                        out_valid;
  smm_pkg::out_item_t          out_item;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [smm_pkg::CFG_AW-1:0]  paddr;
  logic [smm_pkg::CFG_DW-1:0]  pwdata;
  logic [smm_pkg::CFG_DW-1:0]  prdata;
  logic                        pready;

  small_matrix_multiply_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Shadow copies of the element stores and dimension registers.
  logic signed [smm_pkg::DATA_W-1:0] a_elems [smm_pkg::DEPTH];
  logic signed [smm_pkg::DATA_W-1:0] b_elems [smm_pkg::DEPTH];
  logic [smm_pkg::DIM_W-1:0]         dim_inner;
  logic [smm_pkg::DIM_W-1:0]         dim_cols;
  logic [smm_pkg::DIM_W-1:0]         dim_rows;

  smm_pkg::out_item_t pending_products[$];
  int                 mismatch_count;
  int                 cycle_count;
  int                 sender_idle_pct;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch in %s: expected %h, got %h", what, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    smm_pkg::out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_products.size() == 0) begin
        flag_mismatch("unexpected result", 64'd0, 64'(out_item));
      end else begin
        want = pending_products.pop_front();
        if (out_item.result_index !== want.result_index) begin
          flag_mismatch("result_index", 64'(want.result_index), 64'(out_item.result_index));
        end
        if (out_item.result_value !== want.result_value) begin
          flag_mismatch("result_value", 64'(want.result_value), 64'(out_item.result_value));
        end
        if (out_item.last !== want.last) begin
          flag_mismatch("last", 64'(want.last), 64'(out_item.last));
        end
      end
    end
  end

  function automatic int unsigned clamp_dim(input logic [smm_pkg::DIM_W-1:0] v);
    return (v > smm_pkg::MAX_DIM_DEF) ? smm_pkg::MAX_DIM_DEF : int'(v);
  endfunction

  // Full-precision sum of products, floor shift, then saturation to 32 bits.
  function automatic void predict_product();
    int unsigned n, m, rows, r, c, k;
    logic signed [79:0] acc, scaled;
    longint prod;
    smm_pkg::out_item_t res;
    n = clamp_dim(dim_inner);
    m = clamp_dim(dim_cols);
    rows = clamp_dim(dim_rows);
    for (r = 0; r < rows; r++) begin
      for (c = 0; c < m; c++) begin
        acc = '0;
        for (k = 0; k < n; k++) begin
          prod = longint'(b_elems[(r * n + k) % smm_pkg::DEPTH]) *
                 longint'(a_elems[(k * m + c) % smm_pkg::DEPTH]);
          acc = acc + {{16{prod[63]}}, prod};
        end
        scaled = acc >>> FRAC;
        if (scaled > SAT_POS) begin
          res.result_value = VAL_MAX;
        end else if (scaled < SAT_NEG) begin
          res.result_value = VAL_MIN;
        end else begin
          res.result_value = scaled[smm_pkg::DATA_W-1:0];
        end
        res.result_index = smm_pkg::ADDR_W'(r * m + c);
        res.last = (r == rows - 1) && (c == m - 1);
        pending_products.push_back(res);
      end
    end
  endfunction

  function automatic void apply_item(input smm_pkg::in_item_t item);
    case (item.req_type)
      smm_pkg::REQ_LOAD_A: begin
        a_elems[item.elem_index] = item.elem_value;
      end
      smm_pkg::REQ_LOAD_B: begin
        b_elems[item.elem_index] = item.elem_value;
      end
      smm_pkg::REQ_COMPUTE: begin
        predict_product();
      end
      default: begin
      end
    endcase
  endfunction

  function automatic smm_pkg::in_item_t make_item(input logic [1:0] req,
                                                  input logic [smm_pkg::ADDR_W-1:0] idx,
                                                  input logic signed [smm_pkg::DATA_W-1:0] val);
    smm_pkg::in_item_t item;
    item.req_type = req;
    item.elem_index = idx;
    item.elem_value = val;
    return item;
  endfunction

  function automatic logic signed [smm_pkg::DATA_W-1:0] rand_value();
    logic signed [smm_pkg::DATA_W-1:0] v;
    v = $urandom();
    case ($urandom_range(0, 5))
      0: v = v >>> 10;
      1: v = ($signed($urandom_range(0, 15)) - 8) <<< FRAC;
      2: begin
        case ($urandom_range(0, 3))
          0: v = VAL_MAX;
          1: v = VAL_MIN;
          2: v = '0;
          default: v = '1;
        endcase
      end
      default: begin
      end
    endcase
    return v;
  endfunction

  // Waits out random sender idle cycles, then holds the item until a transfer.
  task automatic send_item(input smm_pkg::in_item_t item);
    int gaps;
    gaps = 0;
    while ($urandom_range(0, 99) < sender_idle_pct) gaps++;
    if (gaps > 0) begin
      @(negedge clk);
      start <= 1'b0;
      in_item <= make_item(2'($urandom()), 6'($urandom()), $urandom());
      repeat (gaps - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (busy);
    apply_item(item);
  endtask

  task automatic wait_drain(input int extra);
    @(negedge clk);
    start <= 1'b0;
    while (pending_products.size() != 0 || busy) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic cfg_read_check(input logic [1:0] reg_sel,
                                input logic [smm_pkg::DIM_W-1:0] want);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= smm_pkg::CFG_AW'({reg_sel, 2'b00});
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[smm_pkg::DIM_W-1:0] !== want) begin
      flag_mismatch("register read", 64'(want), 64'(prdata[smm_pkg::DIM_W-1:0]));
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic cfg_write(input logic [1:0] reg_sel, input logic [smm_pkg::DIM_W-1:0] dim);
    logic [smm_pkg::CFG_DW-1:0] wdata;
    // Upper data bits are noise; only the low nibble is kept.
    wdata = $urandom();
    wdata[smm_pkg::DIM_W-1:0] = dim;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= smm_pkg::CFG_AW'({reg_sel, 2'b00});
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (reg_sel)
      smm_pkg::REG_INNER_LEN: dim_inner = dim;
      smm_pkg::REG_OUT_COLS:  dim_cols = dim;
      smm_pkg::REG_OUT_ROWS:  dim_rows = dim;
      default: begin
      end
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cfg_read_check(reg_sel, dim);
  endtask

  task automatic set_dims(input logic [smm_pkg::DIM_W-1:0] inner,
                          input logic [smm_pkg::DIM_W-1:0] cols,
                          input logic [smm_pkg::DIM_W-1:0] rows);
    wait_drain(DRAIN_CYCLES);
    cfg_write(smm_pkg::REG_INNER_LEN, inner);
    cfg_write(smm_pkg::REG_OUT_COLS, cols);
    cfg_write(smm_pkg::REG_OUT_ROWS, rows);
  endtask

  task automatic send_compute();
    send_item(make_item(smm_pkg::REQ_COMPUTE, 6'($urandom()), $urandom()));
  endtask

  task automatic test_reset_values();
    cfg_read_check(smm_pkg::REG_INNER_LEN, 4'd1);
    cfg_read_check(smm_pkg::REG_OUT_COLS, 4'd1);
    cfg_read_check(smm_pkg::REG_OUT_ROWS, 4'd1);
  endtask

  // Single-element products at the reset size: saturation, floor rounding,
  // ignored compute fields and the unused request code.
  task automatic test_single_element();
    send_item(make_item(smm_pkg::REQ_LOAD_A, 6'd0, VAL_MAX));
    send_item(make_item(smm_pkg::REQ_LOAD_B, 6'd0, VAL_MAX));
    send_compute();
    send_item(make_item(smm_pkg::REQ_LOAD_A, 6'd0, VAL_MIN));
    send_compute();
    send_item(make_item(smm_pkg::REQ_LOAD_B, 6'd0, VAL_MIN));
    send_compute();
    send_item(make_item(smm_pkg::REQ_LOAD_A, 6'd0, -32'sd1));
    send_item(make_item(smm_pkg::REQ_LOAD_B, 6'd0, 32'sd1));
    send_compute();
    send_item(make_item(smm_pkg::REQ_LOAD_A, 6'd0, 32'sh0001_0000));
    send_item(make_item(smm_pkg::REQ_LOAD_B, 6'd0, 32'shFFFE_8000));
    send_item(make_item(REQ_UNUSED, 6'd63, $urandom()));
    send_item(make_item(smm_pkg::REQ_COMPUTE, 6'd63, VAL_MIN));
  endtask

  task automatic test_fill_stores();
    int i;
    for (i = 0; i < smm_pkg::DEPTH; i++) begin
      send_item(make_item(smm_pkg::REQ_LOAD_A, 6'(i), rand_value()));
      send_item(make_item(smm_pkg::REQ_LOAD_B, 6'(i), rand_value()));
    end
  endtask

  task automatic test_dimension_corners();
    set_dims(4'd0, 4'd3, 4'd2);
    send_compute();
    set_dims(4'd2, 4'd0, 4'd3);
    send_compute();
    set_dims(4'd2, 4'd3, 4'd0);
    send_compute();
    set_dims(4'd8, 4'd8, 4'd8);
    send_compute();
    set_dims(4'd15, 4'd12, 4'd9);
    send_compute();
    set_dims(4'd3, 4'd8, 4'd1);
    send_compute();
    // Two products of 2^62 each overflow a 64-bit sum.
    set_dims(4'd2, 4'd1, 4'd1);
    send_item(make_item(smm_pkg::REQ_LOAD_A, 6'd0, VAL_MIN));
    send_item(make_item(smm_pkg::REQ_LOAD_A, 6'd1, VAL_MIN));
    send_item(make_item(smm_pkg::REQ_LOAD_B, 6'd0, VAL_MIN));
    send_item(make_item(smm_pkg::REQ_LOAD_B, 6'd1, VAL_MIN));
    send_compute();
    send_item(make_item(smm_pkg::REQ_LOAD_B, 6'd0, VAL_MAX));
    send_compute();
  endtask

  function automatic logic [smm_pkg::DIM_W-1:0] rand_dim();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) return '0;
    if (pick < 16) return smm_pkg::DIM_W'($urandom_range(9, 15));
    if (pick < 28) return smm_pkg::DIM_W'(smm_pkg::MAX_DIM_DEF);
    return smm_pkg::DIM_W'($urandom_range(1, 4));
  endfunction

  task automatic test_random_traffic(input int idle_pct, input int n_items);
    int sent, batch, i, pick;
    sender_idle_pct = idle_pct;
    sent = 0;
    while (sent < n_items) begin
      set_dims(rand_dim(), rand_dim(), rand_dim());
      batch = $urandom_range(15, 30);
      for (i = 0; i < batch; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          send_item(make_item(pick[0] ? smm_pkg::REQ_LOAD_B : smm_pkg::REQ_LOAD_A,
                              6'($urandom()), rand_value()));
          sent++;
        end else if (pick < 94) begin
          send_compute();
          sent++;
          // Sometimes hold off until every result of this transfer is back.
          if ($urandom_range(0, 7) == 0) wait_drain(0);
        end else begin
          send_item(make_item(REQ_UNUSED, 6'($urandom()), $urandom()));
        end
      end
    end
  endtask

  task automatic finish_run();
    int waited;
    @(negedge clk);
    start <= 1'b0;
    waited = 0;
    while ((pending_products.size() != 0 || busy) && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_products.size() != 0) begin
      flag_mismatch("results never delivered", 64'(pending_products.size()), 64'd0);
    end
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatch_count = 0;
    cycle_count = 0;
    sender_idle_pct = 20;
    dim_inner = 4'd1;
    dim_cols = 4'd1;
    dim_rows = 4'd1;
    foreach (a_elems[i]) begin
      a_elems[i] = '0;
      b_elems[i] = '0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_single_element();
    test_fill_stores();
    test_dimension_corners();
    test_random_traffic(20, 90);
    test_random_traffic(69, 90);
    test_random_traffic(0, 90);
    finish_run();
  end

endmodule

// ----- filelist.f -----
rtl/smm_pkg.sv
rtl/smm_ram.sv
rtl/smm_ctrl.sv
rtl/smm_dpath.sv
rtl/small_matrix_multiply_unit.sv
rtl/smm_checker.sv
dv/tb_small_matrix_multiply_unit.sv
